### hw/rtl/mtd_pkg.sv
`default_nettype none

package mtd_pkg;

  // Transfer encoding selected by the mode register; code three acts as pass-through
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_B64  = 2'd1;
  localparam logic [1:0] MODE_QP   = 2'd2;

  // Decoder state carried from one item to the next
  typedef struct packed {
    logic [1:0] group_phase;
    logic [5:0] group_bits;
    logic [1:0] escape_phase;
    logic [7:0] escape_first;
  } state_t;

  // Up to two decoded bytes caused by one input item
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/mtd_decode.sv
`default_nettype none

module mtd_decode (
  input  wire logic [7:0]    c,
  input  wire logic          end_flag,
  input  wire logic [1:0]    mode,
  input  wire mtd_pkg::state_t st,
  output mtd_pkg::state_t    nst,
  output mtd_pkg::res_t      res
);

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [5:0] B64_PLUS  = 6'd62;
  localparam logic [5:0] B64_SLASH = 6'd63;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_EQ   = 2'd1;
  localparam logic [1:0] ESC_CHAR = 2'd2;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] ch);
    return (ch >= 8'h41) && (ch <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [7:0] ch);
    return (ch >= 8'h61) && (ch <= 8'h7a);
  endfunction

  function automatic logic hex_ok(input logic [7:0] ch);
    return is_digit(ch) || ((ch >= 8'h41) && (ch <= 8'h46)) ||
           ((ch >= 8'h61) && (ch <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] d;
    if (is_digit(ch)) d = ch - 8'h30;
    else if (ch <= 8'h46) d = ch - 8'h37;
    else d = ch - 8'h57;
    return d[3:0];
  endfunction

  function automatic logic b64_ok(input logic [7:0] ch);
    return is_upper(ch) || is_lower(ch) || is_digit(ch) ||
           (ch == CH_PLUS) || (ch == CH_SLASH);
  endfunction

  function automatic logic [5:0] b64_val(input logic [7:0] ch);
    logic [7:0] d;
    if (is_upper(ch)) d = ch - 8'h41;
    else if (is_lower(ch)) d = ch - 8'h47;
    else if (is_digit(ch)) d = ch + 8'h04;
    else if (ch == CH_PLUS) d = {2'b00, B64_PLUS};
    else d = {2'b00, B64_SLASH};
    return d[5:0];
  endfunction

  logic [5:0] x;
  logic [7:0] first;
  logic       plain_go;
  logic       plain_slot1;

  always_comb begin
    nst         = st;
    res         = '0;
    x           = b64_val(c);
    first       = st.escape_first;
    plain_go    = 1'b0;
    plain_slot1 = 1'b0;
    case (mode)
      mtd_pkg::MODE_B64: begin
        if (c == CH_LF || c == CH_EQ) begin
          nst.group_phase = 2'd0;
          nst.group_bits  = 6'd0;
        end else if (b64_ok(c)) begin
          case (st.group_phase)
            2'd0: begin
              nst.group_bits  = x;
              nst.group_phase = 2'd1;
            end
            2'd1: begin
              res.byte0       = {st.group_bits, x[5:4]};
              res.cnt         = 2'd1;
              nst.group_bits  = {2'b00, x[3:0]};
              nst.group_phase = 2'd2;
            end
            2'd2: begin
              res.byte0       = {st.group_bits[3:0], x[5:2]};
              res.cnt         = 2'd1;
              nst.group_bits  = {4'b0000, x[1:0]};
              nst.group_phase = 2'd3;
            end
            default: begin
              res.byte0       = {st.group_bits[1:0], x};
              res.cnt         = 2'd1;
              nst.group_bits  = 6'd0;
              nst.group_phase = 2'd0;
            end
          endcase
        end
      end
      mtd_pkg::MODE_QP: begin
        plain_go = 1'b1;
        if (st.escape_phase == ESC_EQ) begin
          if (hex_ok(c) || c == CH_CR) begin
            nst.escape_first = c;
            nst.escape_phase = ESC_CHAR;
            plain_go         = 1'b0;
          end
        end else if (st.escape_phase == ESC_CHAR) begin
          nst.escape_first = 8'h00;
          if (hex_ok(first) && hex_ok(c)) begin
            nst.escape_phase = ESC_NONE;
            res.byte0        = {hex_val(first), hex_val(c)};
            res.cnt          = 2'd1;
            plain_go         = 1'b0;
          end else if (first == CH_CR && c == CH_LF) begin
            // soft line break
            nst.escape_phase = ESC_NONE;
            plain_go         = 1'b0;
          end else begin
            // bad escape: emit the held char, then treat this one as plain text
            res.byte0   = first;
            res.cnt     = 2'd1;
            plain_slot1 = 1'b1;
          end
        end
        if (plain_go) begin
          if (c == CH_EQ) begin
            nst.escape_phase = ESC_EQ;
          end else begin
            nst.escape_phase = ESC_NONE;
            if (plain_slot1) begin
              res.byte1 = c;
              res.cnt   = 2'd2;
            end else begin
              res.byte0 = c;
              res.cnt   = 2'd1;
            end
          end
        end
      end
      default: begin
        res.byte0 = c;
        res.cnt   = 2'd1;
      end
    endcase

    if (end_flag) begin
      // flush a char held after '=', then clear everything
      if (mode == mtd_pkg::MODE_QP && nst.escape_phase == ESC_CHAR) begin
        if (res.cnt == 2'd0) begin
          res.byte0 = nst.escape_first;
          res.cnt   = 2'd1;
        end else if (res.cnt == 2'd1) begin
          res.byte1 = nst.escape_first;
          res.cnt   = 2'd2;
        end
      end
      nst = '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mtd_out_buf.sv
`default_nettype none

module mtd_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire mtd_pkg::res_t res,
  output logic               free,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,   // [7:0] out_byte
  output logic               out_tlast    // run_last
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] b0_r, b0_nxt;
  logic [7:0] b1_r, b1_nxt;
  logic       fire;

  assign fire       = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = b0_r;
  assign out_tlast  = (cnt_r == 2'd1);
  assign free       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_comb begin
    cnt_nxt = cnt_r;
    b0_nxt  = b0_r;
    b1_nxt  = b1_r;
    if (fire) begin
      cnt_nxt = cnt_r - 2'd1;
      b0_nxt  = b1_r;
    end
    if (load) begin
      cnt_nxt = res.cnt;
      b0_nxt  = res.byte0;
      b1_nxt  = res.byte1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/mime_transfer_decoder.sv
// MIME transfer decoder: turns an email body byte stream into decoded bytes.
// Input channel in_*: one raw byte per item in in_tdata; in_tlast marks the
// final byte of the body and flushes a held quoted-printable char.
// Result channel out_*: one decoded byte per item; out_tlast is high on the
// last result caused by one input item (an input item causes 0, 1 or 2).
// Config channel cfg_*: cfg_tdata[1:0] selects 0 pass-through, 1 base64,
// 2 quoted-printable (3 acts as pass-through). A write also clears the
// decoder state. Write only while no item is in flight; cfg_tready is high.
// Path: an accepted item is held in the input register and decoded in a single
// pass; the result is loaded into the output buffer once that buffer is free,
// and the registered output buffer then presents its first result.
// Throughput: one input item per cycle while each gives at most one result
// and out_tready is high; an item with two results holds the output buffer
// until both are taken by the single result port of the two-entry buffer.
// Stall: when out_tready is low the output buffer holds, the input register
// still takes one more item if it is empty, then in_tready drops.
// Reset (rst_n low, synchronous): mode pass-through, state and buffers empty.
`default_nettype none

module mime_transfer_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] in_byte
  input  wire logic       in_tlast,    // end_of_data
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] out_byte
  output logic            out_tlast,   // run_last
  input  wire logic       cfg_tvalid,
  output logic            cfg_tready,
  input  wire logic [7:0] cfg_tdata    // [1:0] mode, [7:2] zero
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // mode and decoder state
  logic [1:0]      mode_r, mode_nxt;
  mtd_pkg::state_t st_r, st_nxt;
  mtd_pkg::state_t dec_st;
  mtd_pkg::res_t   dec_res;

  logic buf_free;
  logic move;

  assign cfg_tready = 1'b1;
  // advance the held item into the output buffer once that buffer drains
  assign move       = in_v_r && buf_free;
  assign in_tready  = !in_v_r || buf_free;

  mtd_decode u_decode (
    .c        (in_byte_r),
    .end_flag (in_end_r),
    .mode     (mode_r),
    .st       (st_r),
    .nst      (dec_st),
    .res      (dec_res)
  );

  mtd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (move),
    .res        (dec_res),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tready) begin
      in_v_nxt = in_tvalid;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    st_nxt   = st_r;
    if (cfg_tvalid && cfg_tready) begin
      // a mode write drops any partial group or pending escape
      mode_nxt = cfg_tdata[1:0];
      st_nxt   = '0;
    end else if (move) begin
      st_nxt = dec_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= mtd_pkg::MODE_PASS;
      st_r   <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      mode_r <= mode_nxt;
      st_r   <= st_nxt;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

endmodule

`default_nettype wire
